// File: sv/dcsw_pkg.sv
// ----------------------------------------------------------------------------
// dcsw_pkg
// shared codes and types for the dragon curve segment walker
// ----------------------------------------------------------------------------
package dcsw_pkg;

    // input item operation codes
    typedef enum logic [1:0] {
        OP_BEGIN_CLEAR = 2'd0,
        OP_BEGIN_KEEP  = 2'd1,
        OP_ADVANCE     = 2'd2
    } opcode_t;

    // headings, north is towards y minus
    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    // configuration register map
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_ORDER = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_Q8     = 4'd1;

    // register widths and reset values
    localparam int unsigned ORDER_W = 5;
    localparam int unsigned STEP_W  = 16;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd10;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd256;

    // scaled coordinate width
    localparam int unsigned COORD_W = 40;

    // control travelling alongside a grid segment
    typedef struct packed {
        logic valid;
        logic last;
    } seg_ctrl_t;

endpackage

// File: sv/dcsw_walker.sv
// ----------------------------------------------------------------------------
// dcsw_walker
// curve state: heading, grid position, segment count and bounding box;
// registers one grid segment per transfer that produces a result
// ----------------------------------------------------------------------------
module dcsw_walker #(
    parameter int MAX_ORDER = 16,
    parameter int GRID_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_xfer,
    input  logic [1:0]                    in_opcode,
    input  logic signed [20:0]            in_start_x,
    input  logic signed [20:0]            in_start_y,
    input  logic [1:0]                    in_start_dir,
    input  logic [dcsw_pkg::ORDER_W-1:0]  curve_order,
    input  logic                          step_zero,
    input  logic                          take,
    output dcsw_pkg::seg_ctrl_t           seg_ctrl,
    output logic signed [GRID_BITS-1:0]   g_x0,
    output logic signed [GRID_BITS-1:0]   g_y0,
    output logic signed [GRID_BITS-1:0]   g_x1,
    output logic signed [GRID_BITS-1:0]   g_y1,
    output logic signed [GRID_BITS-1:0]   g_min_x,
    output logic signed [GRID_BITS-1:0]   g_min_y,
    output logic signed [GRID_BITS-1:0]   g_max_x,
    output logic signed [GRID_BITS-1:0]   g_max_y
);
    import dcsw_pkg::*;

    localparam int SEG_W = MAX_ORDER + 1;

    typedef struct packed {
        logic                        valid;
        logic signed [GRID_BITS-1:0] min_x;
        logic signed [GRID_BITS-1:0] min_y;
        logic signed [GRID_BITS-1:0] max_x;
        logic signed [GRID_BITS-1:0] max_y;
    } bnd_t;

    // widen the box to cover one point
    function automatic bnd_t include_pt(bnd_t b, logic signed [GRID_BITS-1:0] px,
                                        logic signed [GRID_BITS-1:0] py);
        bnd_t r;
        r = b;
        if (!b.valid) begin
            r.valid = 1'b1;
            r.min_x = px;
            r.max_x = px;
            r.min_y = py;
            r.max_y = py;
        end else begin
            if (px < b.min_x) r.min_x = px;
            if (px > b.max_x) r.max_x = px;
            if (py < b.min_y) r.min_y = py;
            if (py > b.max_y) r.max_y = py;
        end
        return r;
    endfunction

    logic signed [GRID_BITS-1:0] pos_x_reg, pos_x_next;
    logic signed [GRID_BITS-1:0] pos_y_reg, pos_y_next;
    dir_t                        heading_reg, heading_next;
    logic [SEG_W-1:0]            seg_idx_reg, seg_idx_next;
    logic                        active_reg, active_next;
    bnd_t                        bnd_reg, bnd_next;
    seg_ctrl_t                   ctrl_reg, ctrl_next;

    logic signed [GRID_BITS-1:0] x0_reg, y0_reg, x1_reg, y1_reg;

    opcode_t                     op;
    logic                        is_begin;
    logic                        is_adv;
    logic                        emit;
    logic [ORDER_W-1:0]          eff_order;
    logic [SEG_W-1:0]            total_m1;
    logic [SEG_W-1:0]            k;
    logic [SEG_W-1:0]            low_bit;
    logic                        turn_right;
    logic                        last;
    dir_t                        hd;
    logic signed [GRID_BITS-1:0] p0x, p0y, p1x, p1y;
    bnd_t                        bnd_base, bnd_mid, bnd_end;

    // decode and pass length
    always_comb begin
        op        = opcode_t'(in_opcode);
        is_begin  = (op == OP_BEGIN_CLEAR || op == OP_BEGIN_KEEP) &&
                    (curve_order != '0) && !step_zero;
        is_adv    = (op == OP_ADVANCE) && active_reg;
        emit      = in_xfer && (is_begin || is_adv);
        eff_order = (curve_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : curve_order;
        for (int i = 0; i < SEG_W; i++) begin
            total_m1[i] = (i < int'(eff_order));
        end
    end

    // paperfolding turn and one grid step
    always_comb begin
        k          = is_begin ? '0 : seg_idx_reg;
        low_bit    = k & (~k + SEG_W'(1));
        turn_right = ((k & (low_bit << 1)) == '0);
        last       = (k >= total_m1);
        if (is_begin) begin
            hd  = dir_t'(in_start_dir);
            p0x = GRID_BITS'(in_start_x);
            p0y = GRID_BITS'(in_start_y);
        end else begin
            hd  = turn_right ? dir_t'(2'(heading_reg + 2'd1)) :
                               dir_t'(2'(heading_reg - 2'd1));
            p0x = pos_x_reg;
            p0y = pos_y_reg;
        end
        p1x = p0x;
        p1y = p0y;
        case (hd)
            DIR_NORTH: p1y = p0y - GRID_BITS'(1);
            DIR_EAST:  p1x = p0x + GRID_BITS'(1);
            DIR_SOUTH: p1y = p0y + GRID_BITS'(1);
            default:   p1x = p0x - GRID_BITS'(1);
        endcase
    end

    // bounding box over the start point on begin and the end point always
    always_comb begin
        bnd_base = bnd_reg;
        if (is_begin && op == OP_BEGIN_CLEAR) begin
            bnd_base.valid = 1'b0;
        end
        bnd_mid = is_begin ? include_pt(bnd_base, p0x, p0y) : bnd_base;
        bnd_end = include_pt(bnd_mid, p1x, p1y);
    end

    // next state
    always_comb begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        seg_idx_next = seg_idx_reg;
        active_next  = active_reg;
        bnd_next     = bnd_reg;
        ctrl_next    = ctrl_reg;
        if (take) begin
            ctrl_next.valid = 1'b0;
        end
        if (emit) begin
            pos_x_next     = p1x;
            pos_y_next     = p1y;
            heading_next   = hd;
            seg_idx_next   = k + SEG_W'(1);
            active_next    = !last;
            bnd_next       = bnd_end;
            ctrl_next.valid = 1'b1;
            ctrl_next.last  = last;
        end
    end

    // state and segment registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= DIR_NORTH;
            seg_idx_reg <= '0;
            active_reg  <= 1'b0;
            bnd_reg     <= '0;
            ctrl_reg    <= '0;
        end else begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
            seg_idx_reg <= seg_idx_next;
            active_reg  <= active_next;
            bnd_reg     <= bnd_next;
            ctrl_reg    <= ctrl_next;
        end
    end

    // segment payload, no reset
    always_ff @(posedge aclk) begin
        if (emit) begin
            x0_reg <= p0x;
            y0_reg <= p0y;
            x1_reg <= p1x;
            y1_reg <= p1y;
        end
    end

    assign seg_ctrl = ctrl_reg;
    assign g_x0     = x0_reg;
    assign g_y0     = y0_reg;
    assign g_x1     = x1_reg;
    assign g_y1     = y1_reg;
    assign g_min_x  = bnd_reg.min_x;
    assign g_min_y  = bnd_reg.min_y;
    assign g_max_x  = bnd_reg.max_x;
    assign g_max_y  = bnd_reg.max_y;

endmodule

// File: sv/dcsw_scaler.sv
// ----------------------------------------------------------------------------
// dcsw_scaler
// scales the registered grid segment and box by the step and holds the
// result until transfer
// ----------------------------------------------------------------------------
module dcsw_scaler #(
    parameter int GRID_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  dcsw_pkg::seg_ctrl_t                 seg_ctrl,
    input  logic [dcsw_pkg::STEP_W-1:0]         step_q8,
    input  logic signed [GRID_BITS-1:0]         g_x0,
    input  logic signed [GRID_BITS-1:0]         g_y0,
    input  logic signed [GRID_BITS-1:0]         g_x1,
    input  logic signed [GRID_BITS-1:0]         g_y1,
    input  logic signed [GRID_BITS-1:0]         g_min_x,
    input  logic signed [GRID_BITS-1:0]         g_min_y,
    input  logic signed [GRID_BITS-1:0]         g_max_x,
    input  logic signed [GRID_BITS-1:0]         g_max_y,
    output logic                                out_valid,
    output logic signed [dcsw_pkg::COORD_W-1:0] seg_x0,
    output logic signed [dcsw_pkg::COORD_W-1:0] seg_y0,
    output logic signed [dcsw_pkg::COORD_W-1:0] seg_x1,
    output logic signed [dcsw_pkg::COORD_W-1:0] seg_y1,
    output logic                                last_segment,
    output logic signed [dcsw_pkg::COORD_W-1:0] bound_min_x,
    output logic signed [dcsw_pkg::COORD_W-1:0] bound_min_y,
    output logic signed [dcsw_pkg::COORD_W-1:0] bound_max_x,
    output logic signed [dcsw_pkg::COORD_W-1:0] bound_max_y
);
    import dcsw_pkg::*;

    // grid value times unsigned step, wrapped or extended to the output width
    function automatic logic signed [COORD_W-1:0] scale(logic signed [GRID_BITS-1:0] g,
                                                       logic signed [STEP_W:0] s);
        logic signed [GRID_BITS+STEP_W:0] p;
        p = g * s;
        return COORD_W'(p);
    endfunction

    logic signed [STEP_W:0] step_s;
    logic                   valid_reg, valid_next;

    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic                      last_reg;
    logic signed [COORD_W-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;

    assign step_s = $signed({1'b0, step_q8});

    // output valid
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = seg_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // scaled payload, no reset
    always_ff @(posedge aclk) begin
        if (load && seg_ctrl.valid) begin
            x0_reg    <= scale(g_x0, step_s);
            y0_reg    <= scale(g_y0, step_s);
            x1_reg    <= scale(g_x1, step_s);
            y1_reg    <= scale(g_y1, step_s);
            last_reg  <= seg_ctrl.last;
            min_x_reg <= scale(g_min_x, step_s);
            min_y_reg <= scale(g_min_y, step_s);
            max_x_reg <= scale(g_max_x, step_s);
            max_y_reg <= scale(g_max_y, step_s);
        end
    end

    assign out_valid    = valid_reg;
    assign seg_x0       = x0_reg;
    assign seg_y0       = y0_reg;
    assign seg_x1       = x1_reg;
    assign seg_y1       = y1_reg;
    assign last_segment = last_reg;
    assign bound_min_x  = min_x_reg;
    assign bound_min_y  = min_y_reg;
    assign bound_max_x  = max_x_reg;
    assign bound_max_y  = max_y_reg;

endmodule

// File: sv/dragon_curve_segment_walker_core.sv
// ----------------------------------------------------------------------------
// dragon_curve_segment_walker_core: input goes via walker and scaler regs to m_valid
// throughput one item per cycle while m_ready is high, via walker and scaler stages
// items that give no result change no state; s_ready follows the two stage slots
// synchronous active-low reset clears state; curve_order 10, step_q8 256
// ----------------------------------------------------------------------------
module dragon_curve_segment_walker_core #(
    parameter int MAX_ORDER = 16,
    parameter int GRID_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [dcsw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dcsw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_opcode,
    input  logic signed [20:0]                    s_start_x,
    input  logic signed [20:0]                    s_start_y,
    input  logic [1:0]                            s_start_dir,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dcsw_pkg::COORD_W-1:0]   m_seg_x0,
    output logic signed [dcsw_pkg::COORD_W-1:0]   m_seg_y0,
    output logic signed [dcsw_pkg::COORD_W-1:0]   m_seg_x1,
    output logic signed [dcsw_pkg::COORD_W-1:0]   m_seg_y1,
    output logic                                  m_last_segment,
    output logic signed [dcsw_pkg::COORD_W-1:0]   m_bound_min_x,
    output logic signed [dcsw_pkg::COORD_W-1:0]   m_bound_min_y,
    output logic signed [dcsw_pkg::COORD_W-1:0]   m_bound_max_x,
    output logic signed [dcsw_pkg::COORD_W-1:0]   m_bound_max_y
);
    import dcsw_pkg::*;

    logic [ORDER_W-1:0] curve_order_reg, curve_order_next;
    logic [STEP_W-1:0]  step_q8_reg, step_q8_next;

    seg_ctrl_t                   seg_ctrl;
    logic                        scaler_load;
    logic                        s_xfer;
    logic signed [GRID_BITS-1:0] g_x0, g_y0, g_x1, g_y1;
    logic signed [GRID_BITS-1:0] g_min_x, g_min_y, g_max_x, g_max_y;

    // configuration registers
    always_comb begin
        curve_order_next = curve_order_reg;
        step_q8_next     = step_q8_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_CURVE_ORDER: curve_order_next = cfg_wdata[ORDER_W-1:0];
                CFG_STEP_Q8:     step_q8_next     = cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_order_reg <= ORDER_RESET;
            step_q8_reg     <= STEP_RESET;
        end else begin
            curve_order_reg <= curve_order_next;
            step_q8_reg     <= step_q8_next;
        end
    end

    // stage handshake: each slot frees when the one after it can take
    assign scaler_load = !m_valid || m_ready;
    assign s_ready     = !seg_ctrl.valid || scaler_load;
    assign s_xfer      = s_valid && s_ready;

    dcsw_walker #(
        .MAX_ORDER (MAX_ORDER),
        .GRID_BITS (GRID_BITS)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_xfer      (s_xfer),
        .in_opcode    (s_opcode),
        .in_start_x   (s_start_x),
        .in_start_y   (s_start_y),
        .in_start_dir (s_start_dir),
        .curve_order  (curve_order_reg),
        .step_zero    (step_q8_reg == '0),
        .take         (scaler_load),
        .seg_ctrl     (seg_ctrl),
        .g_x0         (g_x0),
        .g_y0         (g_y0),
        .g_x1         (g_x1),
        .g_y1         (g_y1),
        .g_min_x      (g_min_x),
        .g_min_y      (g_min_y),
        .g_max_x      (g_max_x),
        .g_max_y      (g_max_y)
    );

    dcsw_scaler #(
        .GRID_BITS (GRID_BITS)
    ) u_scaler (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (scaler_load),
        .seg_ctrl     (seg_ctrl),
        .step_q8      (step_q8_reg),
        .g_x0         (g_x0),
        .g_y0         (g_y0),
        .g_x1         (g_x1),
        .g_y1         (g_y1),
        .g_min_x      (g_min_x),
        .g_min_y      (g_min_y),
        .g_max_x      (g_max_x),
        .g_max_y      (g_max_y),
        .out_valid    (m_valid),
        .seg_x0       (m_seg_x0),
        .seg_y0       (m_seg_y0),
        .seg_x1       (m_seg_x1),
        .seg_y1       (m_seg_y1),
        .last_segment (m_last_segment),
        .bound_min_x  (m_bound_min_x),
        .bound_min_y  (m_bound_min_y),
        .bound_max_x  (m_bound_max_x),
        .bound_max_y  (m_bound_max_y)
    );

`ifndef ASSERT_OFF
    // a valid begin always yields a registered segment
    a_begin_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (s_opcode == OP_BEGIN_CLEAR || s_opcode == OP_BEGIN_KEEP) &&
         curve_order_reg != '0 && step_q8_reg != '0) |=> seg_ctrl.valid)
        else $error("begin transfer gave no segment");

    // a segment held in the walker slot is not lost while the scaler is stalled
    a_slot_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (seg_ctrl.valid && !scaler_load) |=> seg_ctrl.valid)
        else $error("walker slot dropped a stalled segment");

    // grid box is ordered whenever a segment is waiting
    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_ctrl.valid |-> (g_min_x <= g_max_x && g_min_y <= g_max_y))
        else $error("bounding box min above max");

    // segment end lies one grid cell from its start
    a_unit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_ctrl.valid |-> ((g_x0 == g_x1) != (g_y0 == g_y1)))
        else $error("segment is not a single grid step");
`endif

endmodule
